### rtl/gbr_pkg.sv
`default_nettype none
package gbr_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// Configuration registers.
	localparam int CFG_W      = 12;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int MIN_SIZE   = 3;
	localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// Input operation codes.
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef logic [23:0] rgb_t;

	// Binomial tap weights 1, 4, 6, 4, 1.
	typedef logic [2:0] tap_t;
	localparam tap_t BINOM [5] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

	// Five vertically weighted pixels of one channel, then horizontally weighted.
	function automatic logic [7:0] blur_channel(input logic [7:0] p [5][5]);
		logic [11:0] vsum [5];
		logic [15:0] hsum;
		hsum = '0;
		for (int j = 0; j < 5; j++) begin
			vsum[j] = '0;
			for (int k = 0; k < 5; k++) begin
				vsum[j] = vsum[j] + 12'(p[k][j]) * 12'(BINOM[k]);
			end
			hsum = hsum + 16'(vsum[j]) * 16'(BINOM[j]);
		end
		return hsum[15:8];
	endfunction

endpackage
`default_nettype wire

### rtl/gaussian_blur_5x5_rgb_unit.sv
`default_nettype none
// 5x5 binomial blur of an RGB pixel stream, edges clamped to the nearest pixel.
// Input channel: in_valid / in_stall with operation, red, green, blue. Pixels
// arrive in raster order; after a frame the source sends 2*frame_width drain
// beats (operation = 1) to flush the last two rows. Beats of the wrong kind for
// the current phase are taken and dropped.
// Output channel: out_valid / out_stall with the three blurred channels,
// last_of_run on the final result of an input beat, and frame_done on the
// result for the bottom right pixel.
// A beat is taken at a clock edge; its results pass through stage 1, stage 2
// and the output register. The block takes one beat per cycle while the output
// is not stalled, except that the last beat of a row, from the third row on,
// produces three results and holds the input while the window is shifted
// twice more. Line buffers are four single-port banks, read and written at
// the current column in the cycle a beat is taken.
// Reset sets 640 x 480, restarts the frame and empties the pipeline; the line
// buffers are not cleared, since every read hits an entry written earlier in
// the same frame. A configuration write also restarts the frame.
// When the receiver stalls, the output beat holds and the stages behind it
// keep filling until full, after which in_stall rises.
module gaussian_blur_5x5_rgb_unit #(
	parameter int MAX_WIDTH  = gbr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gbr_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gbr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [gbr_pkg::PDATA_W-1:0] pwdata,
	output logic      [gbr_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        operation,
	input  wire logic [7:0]                  red,
	input  wire logic [7:0]                  green,
	input  wire logic [7:0]                  blue,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [7:0]                       blurred_red,
	output logic [7:0]                       blurred_green,
	output logic [7:0]                       blurred_blue,
	output logic                             last_of_run,
	output logic                             frame_done
);
	import gbr_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT + 2);
	localparam int CMP_W = ((RW > CFG_W) ? RW : CFG_W) + 2;

	// Configuration registers.
	logic [CFG_W-1:0] width_q, height_q;
	logic             cfg_wr;
	logic [CFG_W-1:0] wr_val, wr_clamped;
	logic             wr_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign wr_val = pwdata[CFG_W-1:0];
	assign wr_idx = paddr[2];

	always_comb begin
		wr_clamped = wr_val;
		if (32'(wr_val) < 32'(MIN_SIZE)) begin
			wr_clamped = CFG_W'(MIN_SIZE);
		end else if (wr_idx == REG_FRAME_WIDTH && 32'(wr_val) > 32'(MAX_WIDTH)) begin
			wr_clamped = CFG_W'(MAX_WIDTH);
		end else if (wr_idx == REG_FRAME_HEIGHT && 32'(wr_val) > 32'(MAX_HEIGHT)) begin
			wr_clamped = CFG_W'(MAX_HEIGHT);
		end
	end

	always_comb begin
		unique case (wr_idx)
			REG_FRAME_WIDTH:  prdata = PDATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = PDATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_wr) begin
			if (wr_idx == REG_FRAME_WIDTH) begin
				width_q <= wr_clamped;
			end else begin
				height_q <= wr_clamped;
			end
		end
	end

	// Position of the next input beat.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic [CMP_W-1:0] c_x, r_x, w_x, h_x;
	logic             accept, is_drain, active, wr_pix;
	logic             in_frame, col_last;

	assign accept   = in_valid && !in_stall;
	assign is_drain = (operation == OP_DRAIN);
	assign w_x      = CMP_W'(width_q);
	assign h_x      = CMP_W'(height_q);

	always_comb begin
		c = col_q;
		r = row_q;
		if (CMP_W'(col_q) >= w_x || CMP_W'(row_q) >= h_x + CMP_W'(2)) begin
			c = '0;
			r = '0;
		end
	end

	assign c_x      = CMP_W'(c);
	assign r_x      = CMP_W'(r);
	assign in_frame = (r_x < h_x);
	assign active   = in_frame ? !is_drain : is_drain;
	assign wr_pix   = accept && active && !is_drain;
	assign col_last = (c_x == w_x - CMP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && active) begin
			if (col_last) begin
				col_q <= '0;
				if (r_x + CMP_W'(1) >= h_x + CMP_W'(2)) begin
					row_q <= '0;
				end else begin
					row_q <= r + RW'(1);
				end
			end else begin
				col_q <= c + CW'(1);
			end
		end
	end

	// Source row of each window row, clamped to the frame.
	logic [1:0] sel_now [5];
	logic       cur_now [5];
	logic signed [CMP_W:0] t_row;
	logic [CMP_W-1:0]      q_row;

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			t_row = $signed({1'b0, r_x}) - $signed((CMP_W+1)'(4 - k));
			if (t_row < 0) begin
				q_row = '0;
			end else begin
				q_row = t_row[CMP_W-1:0];
			end
			if (q_row > h_x - CMP_W'(1)) begin
				q_row = h_x - CMP_W'(1);
			end
			sel_now[k] = q_row[1:0];
			cur_now[k] = (q_row == r_x);
		end
	end

	// Line buffer banks, one per row modulo four.
	rgb_t pix_now;
	rgb_t rd_s1 [4];
	assign pix_now = {red, green, blue};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		rgb_t bank_mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (accept) begin
				rd_s1[b] <= bank_mem[c];
				if (wr_pix && r[1:0] == 2'(b)) begin
					bank_mem[c] <= pix_now;
				end
			end
		end
	end

	// Stage 1: taken beat with its read data.
	logic       valid_s1;
	rgb_t       pix_s1;
	logic [1:0] sel_s1 [5];
	logic       cur_s1 [5];
	logic       c0_s1, emit_s1, multi_s1, lastrow_s1;
	logic [1:0] phase_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pix_now;
			sel_s1     <= sel_now;
			cur_s1     <= cur_now;
			c0_s1      <= (c_x == '0);
			emit_s1    <= (r_x >= CMP_W'(2)) && (c_x >= CMP_W'(2));
			multi_s1   <= (r_x >= CMP_W'(2)) && col_last;
			lastrow_s1 <= (r_x == h_x + CMP_W'(1));
		end
	end

	// Stage 2: window register and pending result flags.
	rgb_t win_q [5][5];
	rgb_t vcol [5];
	logic valid_s2, last_s2, done_s2;
	logic out_adv, s2_free, s1_step, s1_leave, step_last;

	assign out_adv   = !out_valid || !out_stall;
	assign s2_free   = !valid_s2 || out_adv;
	assign s1_step   = valid_s1 && s2_free;
	assign step_last = !multi_s1 || (phase_q == 2'd2);
	assign s1_leave  = s1_step && step_last;
	assign in_stall  = valid_s1 && !s1_leave;

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			vcol[k] = cur_s1[k] ? pix_s1 : rd_s1[sel_s1[k]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= active;
			end else if (s1_leave) begin
				valid_s1 <= 1'b0;
			end
			if (s1_leave) begin
				phase_q <= '0;
			end else if (s1_step) begin
				phase_q <= phase_q + 2'd1;
			end
			if (s1_step) begin
				valid_s2 <= emit_s1;
			end else if (out_adv) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_step) begin
			last_s2 <= step_last;
			done_s2 <= multi_s1 && step_last && lastrow_s1;
			for (int k = 0; k < 5; k++) begin
				if (phase_q == 2'd0 && c0_s1) begin
					for (int j = 0; j < 5; j++) begin
						win_q[k][j] <= vcol[k];
					end
				end else begin
					for (int j = 0; j < 4; j++) begin
						win_q[k][j] <= win_q[k][j+1];
					end
					win_q[k][4] <= vcol[k];
				end
			end
		end
	end

	// Output register.
	logic [7:0] ch_r [5][5];
	logic [7:0] ch_g [5][5];
	logic [7:0] ch_b [5][5];

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			for (int j = 0; j < 5; j++) begin
				ch_r[k][j] = win_q[k][j][23:16];
				ch_g[k][j] = win_q[k][j][15:8];
				ch_b[k][j] = win_q[k][j][7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_adv) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			blurred_red   <= blur_channel(ch_r);
			blurred_green <= blur_channel(ch_g);
			blurred_blue  <= blur_channel(ch_b);
			last_of_run   <= last_s2;
			frame_done    <= done_s2;
		end
	end

endmodule
`default_nettype wire

### dv/gaussian_blur_5x5_rgb_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module gaussian_blur_5x5_rgb_unit_tb;
	import gbr_pkg::*;

	localparam int MAXW = DEF_MAX_WIDTH;
	localparam int MAXH = DEF_MAX_HEIGHT;
	localparam int CYCLE_LIMIT = 50000;

	// One result of the blur as seen on the output channel.
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
		logic       done;
	} blur_result_t;

	// One row of the directed stimulus table. A row may carry a typed-in result
	// that must match the head of the expectations after the predictor runs.
	typedef struct {
		op_t        op;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		bit         typed;
		logic [7:0] tr;
		logic [7:0] tg;
		logic [7:0] tb;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic operation;
	logic [7:0] red, green, blue;
	logic out_valid, out_stall;
	logic [7:0] blurred_red, blurred_green, blurred_blue;
	logic last_of_run, frame_done;

	gaussian_blur_5x5_rgb_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_stall(out_stall),
		.blurred_red(blurred_red), .blurred_green(blurred_green),
		.blurred_blue(blurred_blue), .last_of_run(last_of_run),
		.frame_done(frame_done)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Shadow state of the blur: sizes, position, line buffers and window.
	int unsigned blur_w, blur_h;
	int unsigned col_pos, row_pos;
	rgb_t line_bufs [4][MAXW];
	rgb_t win [5][5];
	blur_result_t pending_results [$];

	int errors;
	int results_seen;
	int frames_done_seen;
	longint unsigned cycle_count;
	int send_idle_pct, recv_idle_pct;
	bit hold_recv;

	function automatic int unsigned clamp_frame_size(logic [31:0] v, int unsigned maxv);
		int unsigned s;
		s = 32'(v[11:0]);
		if (s < MIN_SIZE) s = MIN_SIZE;
		if (s > maxv) s = maxv;
		return s;
	endfunction

	function automatic void slide_window(rgb_t column [5]);
		for (int k = 0; k < 5; k++) begin
			for (int j = 0; j < 4; j++) win[k][j] = win[k][j+1];
			win[k][4] = column[k];
		end
	endfunction

	// Weighted 5x5 sum of each of the three channels, truncated by the shift by 8.
	function automatic blur_result_t weigh_window(bit done);
		int unsigned wts [5];
		int unsigned acc [3];
		blur_result_t res;
		wts = '{1, 4, 6, 4, 1};
		acc = '{0, 0, 0};
		for (int k = 0; k < 5; k++)
			for (int j = 0; j < 5; j++) begin
				acc[0] += win[k][j][23:16] * wts[k] * wts[j];
				acc[1] += win[k][j][15:8] * wts[k] * wts[j];
				acc[2] += win[k][j][7:0] * wts[k] * wts[j];
			end
		res.r = 8'(acc[0] >> 8);
		res.g = 8'(acc[1] >> 8);
		res.b = 8'(acc[2] >> 8);
		res.last = 1'b0;
		res.done = done;
		return res;
	endfunction

	// Advances the shadow state by one accepted beat and queues its results.
	function automatic void predict_blur(op_t op, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		int unsigned c, rw, q, n;
		int t;
		bit drain;
		rgb_t pix;
		rgb_t column [5];
		blur_result_t outs [3];
		c = col_pos;
		rw = row_pos;
		drain = (op == OP_DRAIN);
		n = 0;
		if (c >= blur_w || rw >= blur_h + 2) begin
			c = 0;
			rw = 0;
		end
		// A beat of the wrong kind for the phase is dropped without effect.
		if (rw < blur_h && drain) return;
		if (rw >= blur_h && !drain) return;
		pix = drain ? 24'h0 : {r, g, b};
		for (int k = 0; k < 5; k++) begin
			t = int'(rw) - 4 + k;
			if (t < 0) t = 0;
			q = t;
			if (q > blur_h - 1) q = blur_h - 1;
			column[k] = (q == rw) ? pix : line_bufs[q % 4][c];
		end
		if (!drain) line_bufs[rw % 4][c] = pix;
		if (c == 0) begin
			for (int k = 0; k < 5; k++)
				for (int j = 0; j < 5; j++) win[k][j] = column[k];
		end else begin
			slide_window(column);
		end
		if (rw >= 2 && c >= 2) begin
			outs[n++] = weigh_window(1'b0);
			if (c == blur_w - 1) begin
				slide_window(column);
				outs[n++] = weigh_window(1'b0);
				slide_window(column);
				outs[n++] = weigh_window(rw - 2 == blur_h - 1);
			end
			outs[n-1].last = 1'b1;
			for (int i = 0; i < n; i++) pending_results.push_back(outs[i]);
		end
		c++;
		if (c >= blur_w) begin
			c = 0;
			rw++;
			if (rw >= blur_h + 2) rw = 0;
		end
		col_pos = c;
		row_pos = rw;
	endfunction

	// Input driver: offers beats, keeps them steady while stalled. Valid stays
	// high after the last beat until wait_quiet drops it.
	task automatic send_beat(op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_blur(op, r, g, b);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_FRAME_WIDTH) blur_w = clamp_frame_size(value, MAXW);
		else blur_h = clamp_frame_size(value, MAXH);
		col_pos = 0;
		row_pos = 0;
		@(posedge clk);
	endtask

	task automatic read_reg_check(reg_idx_t idx, int unsigned want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'(4 * int'(idx));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[CFG_W-1:0] != want[CFG_W-1:0]) begin
			$error("register %s: expected %0d, actual %0d", idx.name(), want,
				prdata[CFG_W-1:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// The block is idle once nothing is pending; the extra wait covers a
	// beat still in flight that produces no result.
	task automatic wait_quiet();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
	endtask

	// Sends a whole frame of the current size followed by its drain beats.
	// A few stray beats of the wrong kind are mixed in as noise.
	task automatic send_frame(int mode);
		logic [7:0] r, g, b;
		for (int y = 0; y < blur_h; y++)
			for (int x = 0; x < blur_w; x++) begin
				case (mode)
					0: begin
						r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
					end
					1: begin
						r = (x + y) % 2 ? 8'hFF : 8'h00;
						g = ~r;
						b = $urandom_range(1) ? 8'hFF : 8'h00;
					end
					default: begin
						r = 8'(x * 37 + y * 11);
						g = 8'(y * 29);
						b = 8'($urandom);
					end
				endcase
				if ($urandom_range(40) == 0)
					send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
				send_beat(OP_PIXEL, r, g, b);
			end
		for (int i = 0; i < 2 * blur_w; i++) begin
			if ($urandom_range(40) == 0)
				send_beat(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
			send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	// Receiver: random stall, and a long hold-off when the stimulus asks.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Output checker: every taken result is compared with the oldest prediction.
	always @(posedge clk) begin
		blur_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no prediction pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (frame_done) frames_done_seen++;
				if (blurred_red !== want.r) begin
					$error("blurred_red: expected %0d, actual %0d", want.r, blurred_red);
					errors++;
				end
				if (blurred_green !== want.g) begin
					$error("blurred_green: expected %0d, actual %0d", want.g, blurred_green);
					errors++;
				end
				if (blurred_blue !== want.b) begin
					$error("blurred_blue: expected %0d, actual %0d", want.b, blurred_blue);
					errors++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
					errors++;
				end
				if (frame_done !== want.done) begin
					$error("frame_done: expected %0d, actual %0d", want.done, frame_done);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	stim_row_t directed [$];

	initial begin
		stim_row_t row;
		blur_result_t head;
		int sets [4][2];
		errors = 0;
		results_seen = 0;
		frames_done_seen = 0;
		cycle_count = 0;
		hold_recv = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		operation = OP_PIXEL;
		red = '0;
		green = '0;
		blue = '0;
		blur_w = RESET_WIDTH;
		blur_h = RESET_HEIGHT;
		col_pos = 0;
		row_pos = 0;
		foreach (win[k, j]) win[k][j] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of both size registers.
		read_reg_check(REG_FRAME_WIDTH, RESET_WIDTH);
		read_reg_check(REG_FRAME_HEIGHT, RESET_HEIGHT);

		// Directed part on a 3x3 frame. A drain beat ahead of the frame and a
		// pixel after it, during the drain, must both be dropped. An all-white
		// frame blurs to full scale everywhere, which can be read off at a
		// glance: a uniform window blurs to itself (255*256/256 = 255). The
		// last pixel of the frame gives the first three results.
		write_reg(REG_FRAME_WIDTH, 32'd1);
		write_reg(REG_FRAME_HEIGHT, 32'd0);
		read_reg_check(REG_FRAME_WIDTH, MIN_SIZE);
		read_reg_check(REG_FRAME_HEIGHT, MIN_SIZE);
		directed.push_back('{OP_DRAIN, 8'h12, 8'h34, 8'h56, 0, 0, 0, 0});
		for (int i = 0; i < 9; i++)
			directed.push_back('{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF,
				i == 8, 8'hFF, 8'hFF, 8'hFF});
		directed.push_back('{OP_PIXEL, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0});
		for (int i = 0; i < 6; i++)
			directed.push_back('{OP_DRAIN, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0});
		for (int i = 0; i < 9; i++)
			directed.push_back('{OP_PIXEL, i[0] ? 8'hFF : 8'h00, 8'h80, 8'h01,
				0, 0, 0, 0});
		foreach (directed[i]) begin
			row = directed[i];
			send_beat(row.op, row.r, row.g, row.b);
			if (row.typed) begin
				head = pending_results[0];
				if (head.r != row.tr || head.g != row.tg || head.b != row.tb) begin
					$error("directed row %0d: predictor gives %0d/%0d/%0d", i,
						head.r, head.g, head.b);
					errors++;
				end
			end
		end
		for (int i = 0; i < 6; i++)
			send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
		wait_quiet();

		// Long receiver hold-off while beats keep coming, so the block backs up.
		write_reg(REG_FRAME_WIDTH, 32'd8);
		write_reg(REG_FRAME_HEIGHT, 32'd4);
		fork
			send_frame(0);
			begin
				hold_recv = 1'b1;
				repeat (60) @(posedge clk);
				hold_recv = 1'b0;
			end
		join
		wait_quiet();

		// Random small frames in three idling regimes.
		sets = '{'{5, 3}, '{3, 5}, '{4, 3}, '{3, 3}};
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 31 : phase == 1 ? 66 : 0;
			recv_idle_pct = phase == 0 ? 66 : phase == 1 ? 31 : 0;
			for (int s = 0; s < 4; s++) begin
				write_reg(REG_FRAME_WIDTH, sets[s][0]);
				write_reg(REG_FRAME_HEIGHT, sets[s][1]);
				send_frame((phase + s) % 3);
				wait_quiet();
			end
		end

		// Oversized writes clamp to the maximum, then one tall narrow frame.
		write_reg(REG_FRAME_WIDTH, 32'hFFF);
		read_reg_check(REG_FRAME_WIDTH, MAXW);
		write_reg(REG_FRAME_WIDTH, 32'd3);
		write_reg(REG_FRAME_HEIGHT, 32'hFFF);
		read_reg_check(REG_FRAME_HEIGHT, MAXH);
		write_reg(REG_FRAME_HEIGHT, 32'd8);
		send_frame(1);
		wait_quiet();

		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d predicted results never arrived", pending_results.size());
			errors++;
		end
		$display("Covered size clamping at both ends, small frames with drain and");
		$display("stray beats, %0d blurred pixels over %0d frames.", results_seen,
			frames_done_seen);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
